>>> rtl/core/ipt_pkg.sv
package ipt_pkg;

    localparam logic [2:0] OP_KERNEL  = 3'd0;
    localparam logic [2:0] OP_GRAPH   = 3'd1;
    localparam logic [2:0] OP_COPY    = 3'd2;
    localparam logic [2:0] OP_CAP_BEG = 3'd3;
    localparam logic [2:0] OP_CAP_END = 3'd4;
    localparam logic [2:0] OP_EXIT    = 3'd5;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PREFILL = 2'd1;
    localparam logic [1:0] PH_DECODE  = 2'd2;

    localparam logic [1:0] REC_FIRST  = 2'd0;
    localparam logic [1:0] REC_INTER  = 2'd1;
    localparam logic [1:0] REC_SUMM   = 2'd2;

    localparam logic [1:0] CFG_GAP    = 2'd0;
    localparam logic [1:0] CFG_MINL   = 2'd1;
    localparam logic [1:0] CFG_COOL   = 2'd2;

    localparam logic [63:0] PICO_SCALE = 64'd1000000000000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [5:0]  process_slot;
        logic [63:0] timestamp;
    } t_in;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [5:0]  slot_out;
        logic [63:0] time_a;
        logic [63:0] time_b;
        logic [63:0] time_c;
        logic [63:0] avg_token_time;
        logic [63:0] wall_time;
        logic [63:0] milli_tokens_per_sec;
        logic [31:0] count_a;
        logic [31:0] count_b;
        logic [31:0] count_c;
    } t_out;

    typedef struct packed {
        logic [1:0]  phase;
        logic [63:0] pstart;
        logic [63:0] last_act;
        logic [31:0] plaunch;
        logic [63:0] dstart;
        logic [63:0] last_tok;
        logic [31:0] tokens;
        logic        capture;
        logic [63:0] first_req;
        logic [31:0] completed;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_EVAL, ST_MUL_LO, ST_MUL_HI, ST_DIV, ST_DIV_END,
        ST_WRITE, ST_OUT
    } t_state;

endpackage

>>> rtl/core/inference_phase_tracker.sv
// Per-slot inference phase tracker. One event transaction is taken at a time;
// the slot entry is read from on-chip memory (registered read), evaluated, and
// written back. Every event passes through read, evaluate, the low and high
// halves of the 64-bit rate product and write before the block is ready again.
// An event that produces a record then passes through an output state that
// loads the output register, and it waits there while the previous record is
// still unaccepted. A transaction that completes a request also runs a shared
// 64-step restoring divider twice (average token time, then token rate), each
// pass closed by a separate end state. The result waits in an output register
// while the next event may already be taken. Slot validity lives in flip-flops
// that reset clears; the rest of each entry is written when the entry is
// created.
module inference_phase_tracker
    import ipt_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state r_state, n_state;
    logic [31:0] r_gap_lim, r_min_l, r_cool;
    logic [SLOTS-1:0] r_valid;
    t_entry mem [SLOTS];
    t_entry r_rd, r_ent;
    t_in r_ev;
    t_out r_res, r_odata;
    logic r_emit, r_ovalid;
    logic [SW-1:0] r_idx;
    logic r_inrange;

    // Divider and multiplier datapath.
    logic [63:0] r_num, r_den, r_q, r_rem;
    logic [6:0]  r_cnt;
    logic        r_div_pass;
    logic [63:0] r_mlo;
    logic [31:0] r_mhi;

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_lim <= 32'd200000;
            r_min_l   <= 32'd10;
            r_cool    <= 32'd100000000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAP:  r_gap_lim <= i_cfg_data;
                CFG_MINL: r_min_l   <= i_cfg_data;
                CFG_COOL: r_cool    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_valid) n_state = ST_READ;
            ST_READ:    n_state = ST_EVAL;
            ST_EVAL:    n_state = ST_MUL_LO;
            ST_MUL_LO:  n_state = ST_MUL_HI;
            ST_MUL_HI:  n_state = (r_emit && r_res.record_kind == REC_SUMM)
                                  ? ST_DIV : ST_WRITE;
            ST_DIV:     if (r_cnt == 7'd63) n_state = ST_DIV_END;
            ST_DIV_END: n_state = r_div_pass ? ST_WRITE : ST_DIV;
            ST_WRITE:   n_state = r_emit ? ST_OUT : ST_IDLE;
            ST_OUT:     if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_ev      <= i_data;
            r_inrange <= ({26'd0, i_data.process_slot} < SLOTS);
            r_idx     <= SW'(i_data.process_slot);
        end
        if (r_state == ST_READ) r_rd <= mem[r_idx];
        if (r_state == ST_WRITE && r_inrange) mem[r_idx] <= r_ent;
    end

    // Event evaluation, in the cycle after the entry read.
    t_entry e;
    t_out   res;
    logic   emit, setv, clrv, summ;
    logic [63:0] now, gap, ttft, gen;
    always_comb begin
        e = r_rd; res = '0; emit = 1'b0; setv = 1'b0; clrv = 1'b0; summ = 1'b0;
        now = r_ev.timestamp;
        gap = now - r_rd.last_act;
        ttft = (r_rd.dstart > r_rd.pstart) ? r_rd.dstart - r_rd.pstart : 64'd0;
        gen  = (r_rd.last_act > r_rd.dstart) ? r_rd.last_act - r_rd.dstart : 64'd0;
        res.slot_out = r_ev.process_slot;
        if (r_inrange) begin
            case (r_ev.opcode)
                OP_KERNEL: begin
                    if (!r_valid[r_idx]) begin
                        setv = 1'b1;
                        e.phase = PH_PREFILL; e.pstart = now; e.last_act = now;
                        e.plaunch = 32'd1; e.dstart = '0; e.last_tok = '0;
                        e.tokens = '0; e.capture = 1'b0; e.first_req = now;
                        e.completed = '0;
                    end else if (!r_rd.capture) begin
                        if (r_rd.phase == PH_IDLE) begin
                            e.phase = PH_PREFILL; e.pstart = now; e.last_act = now;
                            e.plaunch = 32'd1; e.dstart = '0; e.last_tok = '0;
                            e.tokens = '0;
                            if (r_rd.first_req == 64'd0) e.first_req = now;
                        end else if (r_rd.phase == PH_PREFILL) begin
                            if (gap > {32'd0, r_gap_lim} && r_rd.plaunch >= r_min_l) begin
                                emit = 1'b1;
                                res.record_kind = REC_FIRST;
                                res.time_a = r_rd.last_act - r_rd.pstart;
                                res.time_b = r_rd.pstart;
                                res.time_c = r_rd.last_act;
                                res.count_a = r_rd.plaunch;
                                e.phase = PH_DECODE; e.dstart = now; e.last_act = now;
                                e.last_tok = '0; e.tokens = '0;
                            end else begin
                                e.last_act = now;
                                e.plaunch = r_rd.plaunch + 32'd1;
                            end
                        end else if (gap > {32'd0, r_cool}) begin
                            summ = 1'b1;
                            e.phase = PH_PREFILL; e.pstart = now; e.last_act = now;
                            e.plaunch = 32'd1; e.dstart = '0; e.last_tok = '0;
                            e.tokens = '0;
                        end else begin
                            e.last_act = now;
                        end
                    end
                end
                OP_GRAPH, OP_COPY: begin
                    if (r_valid[r_idx]) begin
                        if (r_rd.phase == PH_PREFILL && r_ev.opcode == OP_GRAPH) begin
                            e.last_act = now;
                        end else if (r_rd.phase == PH_DECODE) begin
                            if (gap > {32'd0, r_cool}) begin
                                summ = 1'b1;
                                e.phase = PH_IDLE;
                            end else begin
                                e.last_act = now;
                                if (r_ev.opcode == OP_COPY) begin
                                    e.tokens = r_rd.tokens + 32'd1;
                                    e.last_tok = now;
                                    if (r_rd.last_tok != 64'd0) begin
                                        emit = 1'b1;
                                        res.record_kind = REC_INTER;
                                        res.time_a = now - r_rd.last_tok;
                                        res.count_a = r_rd.tokens;
                                    end
                                end
                            end
                        end
                    end
                end
                OP_CAP_BEG, OP_CAP_END: begin
                    if (r_valid[r_idx]) e.capture = (r_ev.opcode == OP_CAP_BEG);
                end
                OP_EXIT: clrv = 1'b1;
                default: ;
            endcase
        end
        if (summ) begin
            emit = 1'b1;
            e.completed = r_rd.completed + 32'd1;
            res.record_kind = REC_SUMM;
            res.time_a = ttft;
            res.time_b = r_rd.last_act - r_rd.pstart;
            res.time_c = gen;
            res.wall_time = (r_rd.first_req != 64'd0) ? now - r_rd.first_req : 64'd0;
            res.count_a = r_rd.tokens;
            res.count_b = r_rd.plaunch;
            res.count_c = r_rd.completed + 32'd1;
        end
    end

    // Division steps.
    logic [64:0] trial;
    assign trial = {r_rem, r_num[63]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_EVAL) begin
                if (setv) r_valid[r_idx] <= 1'b1;
                if (clrv) r_valid[r_idx] <= 1'b0;
            end
            if (r_state == ST_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready)                    r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_EVAL: begin
                r_ent <= e; r_res <= res; r_emit <= emit;
                r_div_pass <= 1'b0;
                // First pass: average token time.
                r_num <= gen;
                r_den <= (r_rd.tokens > 32'd1) ? {32'd0, r_rd.tokens - 32'd1} : 64'd1;
            end
            ST_MUL_LO: r_mlo <= {32'd0, r_res.count_a} * {32'd0, PICO_SCALE[31:0]};
            ST_MUL_HI: begin
                r_mhi <= r_res.count_a * PICO_SCALE[63:32];
                r_cnt <= '0; r_rem <= '0;
            end
            ST_DIV: begin
                if (!trial[64]) r_rem <= trial[63:0];
                else            r_rem <= {r_rem[62:0], r_num[63]};
                r_num <= {r_num[62:0], 1'b0};
                r_q   <= {r_q[62:0], ~trial[64]};
                r_cnt <= r_cnt + 7'd1;
            end
            ST_DIV_END: begin
                if (!r_div_pass) begin
                    r_res.avg_token_time <= (r_res.count_a == 32'd0) ? 64'd0 : r_q;
                    r_num <= r_mlo + {r_mhi, 32'd0};
                    r_den <= (r_res.time_c == 64'd0) ? 64'd1 : r_res.time_c;
                    r_div_pass <= 1'b1;
                    r_cnt <= '0; r_rem <= '0;
                end else begin
                    r_res.milli_tokens_per_sec <= (r_res.time_c == 64'd0) ? 64'd0 : r_q;
                end
            end
            ST_OUT: if (!r_ovalid || i_ready) r_odata <= r_res;
            default: ;
        endcase
    end

    a_div_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_den != 64'd0))
        else $error("divider denominator is zero");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !o_ready)
        else $error("ready during division");
    a_out_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> r_emit)
        else $error("output state without a record");

endmodule
